/* design/sqr_pkg.sv */
// Package for the sprite quad rotator: angle constants and the sine/cosine table generator.
// No dependencies.
`default_nettype none
package sqr_pkg;
  localparam int unsigned FullTurn    = 23040;
  localparam int unsigned QuarterTurn = 5760;
  localparam int unsigned EighthTurn  = 2880;
  localparam int unsigned TrigBits    = 16;

  typedef logic [TrigBits-1:0] trig_t;

  // Q1.15 magnitude of sin(t) or cos(t) for t in 0..2880 (degrees times 64), computed at
  // elaboration with the same truncating Taylor series the behavior is defined by.
  function automatic trig_t trig_q15(input logic [11:0] t, input logic want_sin);
    logic [63:0] x, x2, x3, x4, x5, x6, x7, x8, v;
    x  = 64'(t) * 64'd292818;
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x4 = (x2 * x2) >> 30;
    x5 = (x4 * x) >> 30;
    x6 = (x4 * x2) >> 30;
    x7 = (x6 * x) >> 30;
    x8 = (x4 * x4) >> 30;
    if (want_sin) begin
      v = (x + x5 / 64'd120) - (x3 / 64'd6 + x7 / 64'd5040);
    end else begin
      v = ((64'd1 << 30) + x4 / 64'd24 + x8 / 64'd40320) - (x2 / 64'd2 + x6 / 64'd720);
    end
    v = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return trig_t'(v);
  endfunction
endpackage
`default_nettype wire

/* design/sprite_quad_rotator.sv */
// Sprite quad rotator top level: five-stage pipeline producing four vertices per sprite.
// Depends on sqr_pkg.
`default_nettype none
// One sprite beat is taken into a one-entry input register and yields four vertex
// beats on consecutive cycles while the output is not stalled. The next sprite is
// accepted while the previous one is still being stepped through its corners; the
// sprite rate is set by the single vertex output port. The first vertex beat of a
// sprite passes the input, serializer, offset, product and output registers in
// turn. Inside, a five-stage pipeline (angle reduction, sine/cosine read
// from two 2881-entry constant ROMs with registered output, sign fold and offset
// setup, four multipliers per corner, round and saturate) works on up to one sprite
// at a time per stage. The sprite is held in a serializer that steps through the
// corners; each corner beat goes through the product and rounding stages with its own
// valid bit, and a skid-free stall holds every stage in place. A zero angle passes
// corners through unchanged; any other angle, including full turns, rotates about the
// rectangle center with Q1.15 sine and cosine.
module sprite_quad_rotator import sqr_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [COORD_WIDTH-1:0] rect_left_i,
  input  wire signed [COORD_WIDTH-1:0] rect_right_i,
  input  wire signed [COORD_WIDTH-1:0] rect_top_i,
  input  wire signed [COORD_WIDTH-1:0] rect_bottom_i,
  input  wire signed [15:0]            angle_degrees_i,
  input  wire        [31:0]            color_zero_i,
  input  wire        [31:0]            color_one_i,
  input  wire        [31:0]            color_two_i,
  input  wire        [31:0]            color_three_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic       [1:0]             vertex_index_o,
  output logic signed [COORD_WIDTH-1:0] vertex_x_o,
  output logic signed [COORD_WIDTH-1:0] vertex_y_o,
  output logic       [31:0]            vertex_color_o,
  output logic                         last_vertex_o
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;          // doubled center / offsets
  localparam int PW = DW + 17;         // offset times Q1.15
  localparam int SW = PW + 2;          // sum of three terms
  localparam int TabN = EighthTurn + 1;

  // Constant ROMs indexed by 0..2880, filled once from the Taylor series.
  trig_t sin_rom [TabN];
  trig_t cos_rom [TabN];

  initial begin
    for (int i = 0; i < TabN; i++) begin
      sin_rom[i] = trig_q15(12'(i), 1'b1);
      cos_rom[i] = trig_q15(12'(i), 1'b0);
    end
  end

  logic adv;
  assign adv = !out_valid_o || !out_stall_i;

  // Stage 1: reduce angle modulo a full turn into quadrant and remainder.
  logic              s1_v_q;
  logic [1:0]        s1_quad_q;
  logic [12:0]       s1_rem_q;
  logic              s1_zero_q;
  logic signed [CW-1:0] s1_l_q, s1_r_q, s1_t_q, s1_b_q;
  logic [31:0]       s1_c_q [4];
  logic [15:0]       a_red;
  logic [1:0]        a_quad;
  logic [12:0]       a_rem;

  always_comb begin
    logic signed [17:0] a;
    a = 18'(angle_degrees_i);
    // Range -32768..32767: add or subtract at most two full turns.
    if (a < 0) a = a + 18'sd23040;
    if (a < 0) a = a + 18'sd23040;
    if (a >= 18'sd23040) a = a - 18'sd23040;
    a_red = a[15:0];
    if (a_red >= 16'd17280) begin
      a_quad = 2'd3; a_rem = 13'(a_red - 16'd17280);
    end else if (a_red >= 16'd11520) begin
      a_quad = 2'd2; a_rem = 13'(a_red - 16'd11520);
    end else if (a_red >= 16'd5760) begin
      a_quad = 2'd1; a_rem = 13'(a_red - 16'd5760);
    end else begin
      a_quad = 2'd0; a_rem = 13'(a_red);
    end
  end

  // Serializer state: a sprite in stage 2 emits corners 0..3.
  logic       s2_v_q;
  logic [1:0] s2_k_q;
  logic       s2_busy;
  assign s2_busy = s2_v_q && (s2_k_q != 2'd3);
  // The input register is free unless the output stalls or it holds a sprite that the serializer cannot take yet.
  assign in_stall_o = !adv || (s1_v_q && s2_busy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= (in_valid_i && !in_stall_o) || (s1_v_q && s2_busy);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i && !in_stall_o) begin
      s1_quad_q <= a_quad;
      s1_rem_q  <= a_rem;
      s1_zero_q <= (angle_degrees_i == 16'sd0);
      s1_l_q <= rect_left_i;  s1_r_q <= rect_right_i;
      s1_t_q <= rect_top_i;   s1_b_q <= rect_bottom_i;
      s1_c_q[0] <= color_zero_i; s1_c_q[1] <= color_one_i;
      s1_c_q[2] <= color_two_i;  s1_c_q[3] <= color_three_i;
    end
  end

  // Stage 2: ROM read of both magnitudes; held for four corners.
  logic               rd_fold;
  logic [11:0]        rd_idx;
  trig_t              s2_sinm_q, s2_cosm_q;
  logic               s2_fold_q;
  logic [1:0]         s2_quad_q;
  logic               s2_zero_q;
  logic signed [CW-1:0] s2_l_q, s2_r_q, s2_t_q, s2_b_q;
  logic [31:0]        s2_c_q [4];

  // Past 45 degrees the remainder is mirrored and sine and cosine swap roles.
  assign rd_fold = (s1_rem_q > 13'(EighthTurn));
  assign rd_idx  = rd_fold ? 12'(13'(QuarterTurn) - s1_rem_q) : 12'(s1_rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s2_k_q <= 2'd0;
    end else if (adv) begin
      if (s1_v_q && !s2_busy) begin
        s2_v_q <= 1'b1;
        s2_k_q <= 2'd0;
      end else if (s2_busy) begin
        s2_k_q <= s2_k_q + 2'd1;
      end else begin
        s2_v_q <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q && !s2_busy) begin
      s2_sinm_q <= sin_rom[rd_idx]; s2_cosm_q <= cos_rom[rd_idx];
      s2_fold_q <= rd_fold; s2_quad_q <= s1_quad_q; s2_zero_q <= s1_zero_q;
      s2_l_q <= s1_l_q; s2_r_q <= s1_r_q; s2_t_q <= s1_t_q; s2_b_q <= s1_b_q;
      s2_c_q <= s1_c_q;
    end
  end

  // Stage 3: quadrant sign fold and one corner's offsets from the center, in doubled units.
  logic                 s3_v_q, s3_last_q, s3_zero_q;
  logic [1:0]           s3_k_q;
  logic signed [DW-1:0] s3_cx_q, s3_cy_q, s3_dx_q, s3_dy_q;
  logic signed [CW-1:0] s3_px_q, s3_py_q;
  logic signed [16:0]   s3_sin_q, s3_cos_q;
  logic [31:0]          s3_col_q;
  logic signed [16:0]   f_sin, f_cos;

  always_comb begin
    logic signed [16:0] bs, bc;
    bs = 17'(s2_fold_q ? s2_cosm_q : s2_sinm_q);
    bc = 17'(s2_fold_q ? s2_sinm_q : s2_cosm_q);
    case (s2_quad_q)
      2'd0:    begin f_sin = bs;  f_cos = bc;  end
      2'd1:    begin f_sin = bc;  f_cos = -bs; end
      2'd2:    begin f_sin = -bs; f_cos = -bc; end
      default: begin f_sin = -bc; f_cos = bs;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] px, py;
    logic signed [DW-1:0] cx, cy;
    px = s2_k_q[0] ? s2_r_q : s2_l_q;
    py = s2_k_q[1] ? s2_t_q : s2_b_q;
    cx = DW'(s2_l_q) + DW'(s2_r_q);
    cy = DW'(s2_t_q) + DW'(s2_b_q);
    if (adv) begin
      s3_k_q <= s2_k_q; s3_last_q <= (s2_k_q == 2'd3); s3_zero_q <= s2_zero_q;
      s3_cx_q <= cx; s3_cy_q <= cy;
      s3_dx_q <= (DW'(px) <<< 1) - cx;
      s3_dy_q <= (DW'(py) <<< 1) - cy;
      s3_px_q <= px; s3_py_q <= py;
      s3_sin_q <= f_sin; s3_cos_q <= f_cos;
      s3_col_q <= s2_c_q[s2_k_q];
    end
  end

  // Stage 4: four products.
  logic                 s4_v_q, s4_last_q, s4_zero_q;
  logic [1:0]           s4_k_q;
  logic signed [PW-1:0] s4_dxc_q, s4_dys_q, s4_dxs_q, s4_dyc_q;
  logic signed [DW-1:0] s4_cx_q, s4_cy_q;
  logic signed [CW-1:0] s4_px_q, s4_py_q;
  logic [31:0]          s4_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s4_v_q <= s3_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_dxc_q <= PW'(s3_dx_q) * PW'(s3_cos_q);
      s4_dys_q <= PW'(s3_dy_q) * PW'(s3_sin_q);
      s4_dxs_q <= PW'(s3_dx_q) * PW'(s3_sin_q);
      s4_dyc_q <= PW'(s3_dy_q) * PW'(s3_cos_q);
      s4_cx_q <= s3_cx_q; s4_cy_q <= s3_cy_q;
      s4_px_q <= s3_px_q; s4_py_q <= s3_py_q;
      s4_k_q <= s3_k_q; s4_last_q <= s3_last_q; s4_zero_q <= s3_zero_q;
      s4_col_q <= s3_col_q;
    end
  end

  // Stage 5: sum, round half up, saturate; output register.
  function automatic logic signed [CW-1:0] to_coord(input logic signed [SW-1:0] sum);
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] hi, lo;
    v  = (sum + SW'(32768)) >>> 16;
    hi = SW'((1 << (CW - 1)) - 1);
    lo = -hi - SW'(1);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= s4_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] sx, sy;
    sx = (SW'(s4_cx_q) <<< 15) + SW'(s4_dxc_q) + SW'(s4_dys_q);
    sy = (SW'(s4_cy_q) <<< 15) - SW'(s4_dxs_q) + SW'(s4_dyc_q);
    if (adv) begin
      vertex_index_o <= s4_k_q;
      last_vertex_o  <= s4_last_q;
      vertex_color_o <= s4_col_q;
      vertex_x_o     <= s4_zero_q ? s4_px_q : to_coord(sx);
      vertex_y_o     <= s4_zero_q ? s4_py_q : to_coord(sy);
    end
  end

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_vertex_o == (vertex_index_o == 2'd3)))
    else $error("last flag disagrees with corner number");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_vertex_o) |=> out_valid_o &&
      (vertex_index_o == $past(vertex_index_o) + 2'd1))
    else $error("corner beats out of sequence");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(vertex_index_o) &&
      $stable(vertex_x_o) && $stable(vertex_y_o) && $stable(vertex_color_o))
    else $error("stalled vertex beat changed");
endmodule
`default_nettype wire
